### hw/rtl/plbl_pkg.sv
// Shared package for the path prefix and program name blocklist.
// Holds parameter defaults, request and decision codes, the FSM state type
// and the controller/datapath command and status structs. No dependencies.
`default_nettype none

package plbl_pkg;

	localparam int PATH_LEN_DEF       = 256;
	localparam int NAME_LEN_DEF       = 16;
	localparam int PREFIX_ENTRIES_DEF = 256;
	localparam int NAME_ENTRIES_DEF   = 128;

	// request kinds carried in s_tuser
	localparam logic [1:0] REQ_WR_PREFIX = 2'd0;
	localparam logic [1:0] REQ_WR_NAME   = 2'd1;
	localparam logic [1:0] REQ_CHK_OPEN  = 2'd2;
	localparam logic [1:0] REQ_CHK_EXEC  = 2'd3;

	// decisions carried in m_tdata
	localparam logic [1:0] DEC_AUDIT = 2'd0;
	localparam logic [1:0] DEC_ALLOW = 2'd1;
	localparam logic [1:0] DEC_BLOCK = 2'd2;

	localparam logic KIND_OPEN = 1'b0;
	localparam logic KIND_EXEC = 1'b1;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_SLASH = 8'h2f;

	// configuration register indexes
	localparam logic REG_ENFORCE = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_ADVANCE,
		ST_ZERO,
		ST_NAME_ISSUE,
		ST_NAME_CMP,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic sweep_issue;  // read next prefix entry at current position
		logic advance;      // update basename and position with current char
		logic load_zero;    // current char becomes end of path
		logic name_start;   // rewind the name table walk
		logic name_skip;    // go to next name entry
		logic name_read;    // read name byte
		logic name_step;    // go to next byte of the entry
		logic name_hit;     // record a name match
		logic emit;         // load the result word
		logic clear;        // reset stream state
	} cmd_t;

	typedef struct packed {
		logic done;         // path has ended
		logic last;         // current check word carries last
		logic exec;         // current check word is an exec check
		logic sweep_last;   // prefix walk at final entry
		logic name_valid;   // current name entry active
		logic name_last;    // name walk at final entry
		logic name_eq;      // name byte equals basename byte
		logic name_kzero;   // basename byte is the terminator
		logic out_free;     // result register can take a word
	} sts_t;

endpackage

`default_nettype wire

### hw/rtl/plbl_ram.sv
// Generic simple dual-port RAM with registered read.
// Used for the prefix and name stores; no dependencies.
`default_nettype none

module plbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/plbl_dp.sv
// Datapath: table stores, per-entry flags, stream state, name compare
// and result register. Depends on plbl_pkg and plbl_ram.
`default_nettype none

module plbl_dp #(
	parameter int PATH_LEN       = plbl_pkg::PATH_LEN_DEF,
	parameter int NAME_LEN       = plbl_pkg::NAME_LEN_DEF,
	parameter int PREFIX_ENTRIES = plbl_pkg::PREFIX_ENTRIES_DEF,
	parameter int NAME_ENTRIES   = plbl_pkg::NAME_ENTRIES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire logic [1:0]     req_type,
	input  wire logic [7:0]     entry_index,
	input  wire logic [7:0]     char_position,
	input  wire logic [7:0]     char_value,
	input  wire logic           entry_active,
	input  wire logic           last,
	input  wire logic           enforce,
	input  wire plbl_pkg::cmd_t cmd,
	output      plbl_pkg::sts_t sts,
	output      logic           out_valid,
	input  wire logic           out_ready,
	output      logic [1:0]     decision,
	output      logic           check_kind
);

	localparam int PW = $clog2(PATH_LEN);
	localparam int NW = $clog2(NAME_LEN);
	localparam int EW = (PREFIX_ENTRIES > 1) ? $clog2(PREFIX_ENTRIES) : 1;
	localparam int XW = (NAME_ENTRIES > 1) ? $clog2(NAME_ENTRIES) : 1;
	localparam int PA = EW + PW;
	localparam int NA = XW + NW;

	logic [31:0] idx32, pos32;
	logic        pfx_we, name_we, is_check;
	logic [PA-1:0] pfx_waddr, pfx_raddr;
	logic [NA-1:0] name_waddr, name_raddr;
	logic [7:0]  pfx_rdata, name_rdata, kbyte;

	logic        pvalid_q   [PREFIX_ENTRIES];
	logic        nonempty_q [PREFIX_ENTRIES];
	logic        alive_q    [PREFIX_ENTRIES];
	logic        nvalid_q   [NAME_ENTRIES];
	logic [7:0]  buf_q      [NAME_LEN];

	logic [7:0]    c_q;
	logic [PW-1:0] pos_q;
	logic          done_q, hit_q, last_q, exec_q, match_q;
	logic [NW-1:0] len_q, ni_q;
	logic [EW-1:0] e_q, e_s1;
	logic          en_s1;
	logic [XW-1:0] ne_q;
	logic          matched;

	// decode table writes
	assign idx32     = 32'(entry_index);
	assign pos32     = 32'(char_position);
	assign is_check  = req_type[1];
	assign pfx_we    = accept && (req_type == plbl_pkg::REQ_WR_PREFIX)
		&& (idx32 < PREFIX_ENTRIES) && (pos32 < PATH_LEN);
	assign name_we   = accept && (req_type == plbl_pkg::REQ_WR_NAME)
		&& (idx32 < NAME_ENTRIES) && (pos32 < NAME_LEN);
	assign pfx_waddr  = {idx32[EW-1:0], pos32[PW-1:0]};
	assign name_waddr = {idx32[XW-1:0], pos32[NW-1:0]};
	assign pfx_raddr  = {e_q, pos_q};
	assign name_raddr = {ne_q, ni_q};

	plbl_ram #(.WIDTH(8), .DEPTH(2 ** PA)) u_pfx_ram (
		.clk   (clk),
		.we    (pfx_we),
		.waddr (pfx_waddr),
		.wdata (char_value),
		.re    (cmd.sweep_issue),
		.raddr (pfx_raddr),
		.rdata (pfx_rdata)
	);

	plbl_ram #(.WIDTH(8), .DEPTH(2 ** NA)) u_name_ram (
		.clk   (clk),
		.we    (name_we),
		.waddr (name_waddr),
		.wdata (char_value),
		.re    (cmd.name_read),
		.raddr (name_raddr),
		.rdata (name_rdata)
	);

	// per-entry prefix flags and stream match state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PREFIX_ENTRIES; i++) begin
				pvalid_q[i]   <= 1'b0;
				nonempty_q[i] <= 1'b0;
				alive_q[i]    <= 1'b1;
			end
			hit_q <= 1'b0;
		end else begin
			if (pfx_we) begin
				pvalid_q[idx32[EW-1:0]] <= entry_active;
				if (pos32 == 32'd0) begin
					nonempty_q[idx32[EW-1:0]] <= (char_value != plbl_pkg::CHAR_NUL);
				end
			end
			if (cmd.clear) begin
				for (int i = 0; i < PREFIX_ENTRIES; i++) begin
					alive_q[i] <= 1'b1;
				end
				hit_q <= 1'b0;
			end else if (en_s1 && pvalid_q[e_s1] && alive_q[e_s1] && nonempty_q[e_s1]) begin
				if (pfx_rdata == plbl_pkg::CHAR_NUL) begin
					hit_q         <= 1'b1;
					alive_q[e_s1] <= 1'b0;
				end else if (pfx_rdata != c_q) begin
					alive_q[e_s1] <= 1'b0;
				end
			end
		end
	end

	// name entry active bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NAME_ENTRIES; i++) begin
				nvalid_q[i] <= 1'b0;
			end
		end else if (name_we) begin
			nvalid_q[idx32[XW-1:0]] <= entry_active;
		end
	end

	// prefix walk counter and compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q   <= '0;
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= cmd.sweep_issue;
			e_q   <= cmd.sweep_issue ? e_q + EW'(1) : '0;
		end
	end

	always_ff @(posedge clk) begin
		e_s1 <= e_q;
	end

	// current char, position, basename
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q    <= plbl_pkg::CHAR_NUL;
			pos_q  <= '0;
			done_q <= 1'b0;
			len_q  <= '0;
			last_q <= 1'b0;
			exec_q <= 1'b0;
		end else begin
			if (accept && is_check) begin
				c_q    <= (pos_q == PW'(PATH_LEN - 1)) ? plbl_pkg::CHAR_NUL : char_value;
				last_q <= last;
				exec_q <= (req_type == plbl_pkg::REQ_CHK_EXEC);
			end else if (cmd.load_zero) begin
				c_q <= plbl_pkg::CHAR_NUL;
			end
			if (cmd.clear) begin
				pos_q  <= '0;
				done_q <= 1'b0;
				len_q  <= '0;
			end else if (cmd.advance && !done_q) begin
				if (c_q == plbl_pkg::CHAR_SLASH) begin
					len_q <= '0;
				end else if (c_q != plbl_pkg::CHAR_NUL && len_q < NW'(NAME_LEN - 1)) begin
					len_q <= len_q + NW'(1);
				end
				if (c_q == plbl_pkg::CHAR_NUL) begin
					done_q <= 1'b1;
				end else begin
					pos_q <= pos_q + PW'(1);
				end
			end
		end
	end

	// basename bytes
	always_ff @(posedge clk) begin
		if (cmd.advance && !done_q && c_q != plbl_pkg::CHAR_SLASH
			&& c_q != plbl_pkg::CHAR_NUL && len_q < NW'(NAME_LEN - 1)) begin
			buf_q[len_q] <= c_q;
		end
	end

	// name table walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ne_q    <= '0;
			ni_q    <= '0;
			match_q <= 1'b0;
		end else begin
			if (cmd.name_start) begin
				ne_q    <= '0;
				ni_q    <= '0;
				match_q <= 1'b0;
			end else if (cmd.name_skip) begin
				ne_q <= ne_q + XW'(1);
				ni_q <= '0;
			end else if (cmd.name_step) begin
				ni_q <= ni_q + NW'(1);
			end
			if (cmd.name_hit) begin
				match_q <= 1'b1;
			end
		end
	end

	assign kbyte = (ni_q < len_q) ? buf_q[ni_q] : plbl_pkg::CHAR_NUL;

	// result register
	assign matched = exec_q ? match_q : hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			decision   <= !enforce ? plbl_pkg::DEC_AUDIT
				: (matched ? plbl_pkg::DEC_BLOCK : plbl_pkg::DEC_ALLOW);
			check_kind <= exec_q ? plbl_pkg::KIND_EXEC : plbl_pkg::KIND_OPEN;
		end
	end

	// status to controller
	always_comb begin
		sts.done       = done_q;
		sts.last       = last_q;
		sts.exec       = exec_q;
		sts.sweep_last = (e_q == EW'(PREFIX_ENTRIES - 1));
		sts.name_valid = nvalid_q[ne_q];
		sts.name_last  = (ne_q == XW'(NAME_ENTRIES - 1));
		sts.name_eq    = (name_rdata == kbyte);
		sts.name_kzero = (kbyte == plbl_pkg::CHAR_NUL);
		sts.out_free   = !out_valid || out_ready;
	end

endmodule

`default_nettype wire

### hw/rtl/plbl_ctrl.sv
// Controller FSM: sequences the prefix walk per character, the end-of-path
// step, the name walk and the result. Depends on plbl_pkg.
`default_nettype none

module plbl_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire logic           is_check,
	input  wire plbl_pkg::sts_t sts,
	output      plbl_pkg::cmd_t cmd,
	output      logic           in_ready
);

	plbl_pkg::state_t state_q, state_d;
	logic second_q, second_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= plbl_pkg::ST_IDLE;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			second_q <= second_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		second_d = second_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			plbl_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (accept && is_check) begin
					second_d = 1'b0;
					state_d  = sts.done ? plbl_pkg::ST_ADVANCE : plbl_pkg::ST_SWEEP;
				end
			end
			plbl_pkg::ST_SWEEP: begin
				cmd.sweep_issue = 1'b1;
				if (sts.sweep_last) begin
					state_d = plbl_pkg::ST_DRAIN;
				end
			end
			plbl_pkg::ST_DRAIN: begin
				state_d = plbl_pkg::ST_ADVANCE;
			end
			plbl_pkg::ST_ADVANCE: begin
				cmd.advance = 1'b1;
				if (!sts.last) begin
					state_d = plbl_pkg::ST_IDLE;
				end else if (!second_q) begin
					second_d = 1'b1;
					state_d  = plbl_pkg::ST_ZERO;
				end else if (sts.exec) begin
					cmd.name_start = 1'b1;
					state_d        = plbl_pkg::ST_NAME_ISSUE;
				end else begin
					state_d = plbl_pkg::ST_DECIDE;
				end
			end
			plbl_pkg::ST_ZERO: begin
				cmd.load_zero = 1'b1;
				state_d = sts.done ? plbl_pkg::ST_ADVANCE : plbl_pkg::ST_SWEEP;
			end
			plbl_pkg::ST_NAME_ISSUE: begin
				if (!sts.name_valid) begin
					if (sts.name_last) begin
						state_d = plbl_pkg::ST_DECIDE;
					end else begin
						cmd.name_skip = 1'b1;
					end
				end else begin
					cmd.name_read = 1'b1;
					state_d       = plbl_pkg::ST_NAME_CMP;
				end
			end
			plbl_pkg::ST_NAME_CMP: begin
				if (sts.name_eq && sts.name_kzero) begin
					cmd.name_hit = 1'b1;
					state_d      = plbl_pkg::ST_DECIDE;
				end else if (sts.name_eq) begin
					cmd.name_step = 1'b1;
					state_d       = plbl_pkg::ST_NAME_ISSUE;
				end else if (sts.name_last) begin
					state_d = plbl_pkg::ST_DECIDE;
				end else begin
					cmd.name_skip = 1'b1;
					state_d       = plbl_pkg::ST_NAME_ISSUE;
				end
			end
			plbl_pkg::ST_DECIDE: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					cmd.clear = 1'b1;
					state_d   = plbl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = plbl_pkg::ST_IDLE;
			end
		endcase
	end

	// drain always follows the prefix walk
	a_drain_after_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == plbl_pkg::ST_DRAIN) |-> ($past(state_q) == plbl_pkg::ST_SWEEP))
		else $error("drain without prefix walk");

	// name compare only on data read the cycle before
	a_cmp_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == plbl_pkg::ST_NAME_CMP) |-> $past(cmd.name_read))
		else $error("name compare without read");

	// a result is loaded only into a free result register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result overwritten");

endmodule

`default_nettype wire

### hw/rtl/path_prefix_and_exec_name_blocklist.sv
// Top level of the path prefix and program name blocklist.
// Holds the APB enforce register and joins plbl_ctrl and plbl_dp.
//
// Words on the input stream either write one byte of a prefix or name
// entry or carry one path character of a check. Each path character,
// until the path has ended, walks every prefix entry through the prefix
// store's single read port, one entry per cycle. The word with tlast adds
// a second walk for the end of path unless the path has already ended,
// and for an exec check a name walk that reads and then compares one byte
// at a time, then loads the result once the result register is free. One
// result word follows each check word with tlast; a finished result waits
// in its register while the next word is taken.
`default_nettype none

module path_prefix_and_exec_name_blocklist #(
	parameter int PATH_LEN       = plbl_pkg::PATH_LEN_DEF,
	parameter int NAME_LEN       = plbl_pkg::NAME_LEN_DEF,
	parameter int PREFIX_ENTRIES = plbl_pkg::PREFIX_ENTRIES_DEF,
	parameter int NAME_ENTRIES   = plbl_pkg::NAME_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	// entry_index[7:0], char_position[15:8], char_value[23:16], entry_active[24]
	input  wire logic [31:0] s_tdata,
	// req_type[1:0]
	input  wire logic [1:0]  s_tuser,
	input  wire logic        s_tlast,
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	// decision[1:0]
	output      logic [7:0]  m_tdata,
	// check_kind[0]
	output      logic        m_tuser,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready
);

	logic           enforce_q, accept;
	logic [1:0]     decision;
	plbl_pkg::cmd_t cmd;
	plbl_pkg::sts_t sts;

	assign pready = 1'b1;
	assign accept = s_tvalid && s_tready;

	// enforce register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enforce_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[2] == plbl_pkg::REG_ENFORCE) begin
			enforce_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == plbl_pkg::REG_ENFORCE) ? {31'b0, enforce_q} : 32'b0;

	plbl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.is_check (s_tuser[1]),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (s_tready)
	);

	plbl_dp #(
		.PATH_LEN       (PATH_LEN),
		.NAME_LEN       (NAME_LEN),
		.PREFIX_ENTRIES (PREFIX_ENTRIES),
		.NAME_ENTRIES   (NAME_ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.req_type      (s_tuser),
		.entry_index   (s_tdata[7:0]),
		.char_position (s_tdata[15:8]),
		.char_value    (s_tdata[23:16]),
		.entry_active  (s_tdata[24]),
		.last          (s_tlast),
		.enforce       (enforce_q),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.decision      (decision),
		.check_kind    (m_tuser)
	);

	assign m_tdata = {6'b0, decision};

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking bench for the path prefix and program name blocklist.
// Depends on plbl_pkg and path_prefix_and_exec_name_blocklist; stream words are
// predicted at acceptance and decisions checked in order.
`timescale 1ns / 100ps

module testbench;

	localparam int PLEN  = plbl_pkg::PATH_LEN_DEF;
	localparam int NLEN  = plbl_pkg::NAME_LEN_DEF;
	localparam int PENT  = plbl_pkg::PREFIX_ENTRIES_DEF;
	localparam int NENT  = plbl_pkg::NAME_ENTRIES_DEF;
	localparam int SETTLE_CYCLES = 6000;
	localparam int STALL_LIMIT   = 30000;

	typedef bit [7:0] byte_q_t[$];

	typedef struct {
		bit [1:0] req;
		bit [7:0] idx;
		bit [7:0] pos;
		bit [7:0] ch;
		bit       act;
		bit       last;
	} word_t;

	typedef struct {
		bit [1:0] decision;
		bit       kind;
	} verdict_t;

	logic        clk, arst_n;
	logic        s_tvalid, s_tready, s_tlast;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid, m_tready, m_tuser;
	logic [7:0]  m_tdata;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;

	path_prefix_and_exec_name_blocklist u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	word_t    word_q[$];
	verdict_t verdict_q[$];
	bit       failed;
	bit       calm;
	int       n_words;

	// generation-side view of the tables, ahead of the block
	bit       gp_wr[PENT][PLEN];
	bit [7:0] gp_ch[PENT][PLEN];
	bit       gp_on[PENT];
	bit       gn_wr[NENT][NLEN];
	bit [7:0] gn_ch[NENT][NLEN];
	bit       gn_on[NENT];

	// predictor state, updated as words are accepted
	bit [7:0] pfx_mem[PENT][PLEN];
	bit       pfx_on[PENT];
	bit [7:0] nam_mem[NENT][NLEN];
	bit       nam_on[NENT];
	bit       pfx_live[PENT];
	bit       pfx_hit;
	bit [7:0] base_buf[NLEN];
	int       base_len;
	int       path_pos;
	bit       enforce;

	function automatic void stream_clear();
		for (int e = 0; e < PENT; e++) pfx_live[e] = 1'b1;
		for (int i = 0; i < NLEN; i++) base_buf[i] = 8'd0;
		pfx_hit  = 1'b0;
		base_len = 0;
		path_pos = 0;
	endfunction

	// advance the prefix walk and basename by one path character
	function automatic void path_feed(bit [7:0] c);
		int p;
		bit [7:0] b;
		p = path_pos;
		if (p >= PLEN) return;
		if (p >= PLEN - 1) c = plbl_pkg::CHAR_NUL;
		for (int e = 0; e < PENT; e++) begin
			if (!pfx_on[e] || !pfx_live[e] || pfx_mem[e][0] == plbl_pkg::CHAR_NUL) continue;
			b = pfx_mem[e][p];
			if (b == plbl_pkg::CHAR_NUL) begin
				pfx_hit = 1'b1;
				pfx_live[e] = 1'b0;
			end else if (b != c) begin
				pfx_live[e] = 1'b0;
			end
		end
		if (c == plbl_pkg::CHAR_SLASH) begin
			base_len = 0;
		end else if (c != plbl_pkg::CHAR_NUL && base_len < NLEN - 1) begin
			base_buf[base_len] = c;
			base_len++;
		end
		path_pos = (c == plbl_pkg::CHAR_NUL) ? PLEN : p + 1;
	endfunction

	function automatic bit name_hit();
		bit [7:0] k;
		for (int e = 0; e < NENT; e++) begin
			if (!nam_on[e]) continue;
			for (int i = 0; i < NLEN; i++) begin
				k = (i < base_len) ? base_buf[i] : plbl_pkg::CHAR_NUL;
				if (nam_mem[e][i] != k) break;
				if (k == plbl_pkg::CHAR_NUL) return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void predict_word(word_t w);
		bit hit;
		verdict_t v;
		if (w.req == plbl_pkg::REQ_WR_PREFIX) begin
			if (w.idx < PENT && w.pos < PLEN) begin
				pfx_mem[w.idx][w.pos] = w.ch;
				pfx_on[w.idx] = w.act;
			end
			return;
		end
		if (w.req == plbl_pkg::REQ_WR_NAME) begin
			if (w.idx < NENT && w.pos < NLEN) begin
				nam_mem[w.idx][w.pos] = w.ch;
				nam_on[w.idx] = w.act;
			end
			return;
		end
		path_feed(w.ch);
		if (!w.last) return;
		path_feed(plbl_pkg::CHAR_NUL);
		hit = (w.req == plbl_pkg::REQ_CHK_EXEC) ? name_hit() : pfx_hit;
		v.decision = !enforce ? plbl_pkg::DEC_AUDIT
			: (hit ? plbl_pkg::DEC_BLOCK : plbl_pkg::DEC_ALLOW);
		v.kind     = (w.req == plbl_pkg::REQ_CHK_EXEC) ? plbl_pkg::KIND_EXEC
			: plbl_pkg::KIND_OPEN;
		verdict_q.push_back(v);
		stream_clear();
	endfunction

	// an active entry must have every byte up to its terminator written
	function automatic bit prefix_safe(int e);
		for (int i = 0; i < PLEN; i++) begin
			if (!gp_wr[e][i]) return 1'b0;
			if (gp_ch[e][i] == plbl_pkg::CHAR_NUL) return 1'b1;
		end
		return 1'b1;
	endfunction

	function automatic bit name_safe(int e);
		for (int i = 0; i < NLEN; i++) begin
			if (!gn_wr[e][i]) return 1'b0;
			if (gn_ch[e][i] == plbl_pkg::CHAR_NUL) return 1'b1;
		end
		return 1'b1;
	endfunction

	task automatic queue_word(bit [1:0] req, bit [7:0] idx, bit [7:0] pos, bit [7:0] ch,
			bit act, bit last);
		word_t w;
		w.req = req; w.idx = idx; w.pos = pos; w.ch = ch; w.act = act; w.last = last;
		word_q.push_back(w);
		n_words++;
		if (req == plbl_pkg::REQ_WR_PREFIX) begin
			gp_wr[idx][pos] = 1'b1;
			gp_ch[idx][pos] = ch;
			gp_on[idx] = act;
		end else if (req == plbl_pkg::REQ_WR_NAME && idx < NENT && pos < NLEN) begin
			gn_wr[idx][pos] = 1'b1;
			gn_ch[idx][pos] = ch;
			gn_on[idx] = act;
		end
	endtask

	// write a whole entry, active bit set only with the terminator
	task automatic load_entry(bit [1:0] req, int idx, byte_q_t s, bit act);
		foreach (s[i]) queue_word(req, 8'(idx), 8'(i), s[i], 1'b0, 1'b0);
		queue_word(req, 8'(idx), 8'(s.size()), plbl_pkg::CHAR_NUL, act, 1'b0);
	endtask

	// one byte at a random spot; active only where the entry stays readable
	task automatic poke_entry(bit [1:0] req);
		bit [7:0] idx, pos, ch;
		bit act;
		idx = 8'($urandom_range(0, 255));
		pos = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 15));
		ch  = 8'($urandom_range(0, 255));
		act = 1'($urandom_range(0, 1));
		queue_word(req, idx, pos, ch, 1'b0, 1'b0);
		if (req == plbl_pkg::REQ_WR_PREFIX) begin
			if (!prefix_safe(idx)) act = 1'b0;
			gp_on[idx] = act;
		end else if (idx < NENT && pos < NLEN) begin
			if (!name_safe(idx)) act = 1'b0;
			gn_on[idx] = act;
		end
		word_q[$].act = act;
	endtask

	task automatic send_path(bit [1:0] kind, byte_q_t s);
		bit [1:0] k;
		foreach (s[i]) begin
			k = kind;
			if (i != s.size() - 1 && $urandom_range(0, 3) == 0)
				k = (kind == plbl_pkg::REQ_CHK_EXEC) ? plbl_pkg::REQ_CHK_OPEN
					: plbl_pkg::REQ_CHK_EXEC;
			queue_word(k, 8'd0, 8'd0, s[i], 1'b0, i == s.size() - 1);
		end
	endtask

	function automatic bit [7:0] rand_char();
		case ($urandom_range(0, 9))
			0:       return 8'($urandom_range(1, 255));
			1, 2:    return plbl_pkg::CHAR_SLASH;
			3:       return ($urandom_range(0, 7) == 0) ? plbl_pkg::CHAR_NUL : "c";
			default: return $urandom_range(0, 1) ? "a" : "b";
		endcase
	endfunction

	function automatic byte_q_t rand_text(int lo, int hi);
		byte_q_t s;
		int n;
		n = $urandom_range(lo, hi);
		repeat (n) s.push_back($urandom_range(0, 3) ? ($urandom_range(0, 1) ? "a" : "b")
			: plbl_pkg::CHAR_SLASH);
		return s;
	endfunction

	function automatic byte_q_t rand_path();
		byte_q_t s;
		int n;
		n = $urandom_range(1, 10);
		repeat (n) s.push_back(rand_char());
		return s;
	endfunction

	function automatic int pick_active(bit want_name);
		int pool[$];
		if (want_name) begin
			for (int e = 0; e < NENT; e++) if (gn_on[e]) pool.push_back(e);
		end else begin
			for (int e = 0; e < PENT; e++)
				if (gp_on[e] && gp_ch[e][0] != plbl_pkg::CHAR_NUL) pool.push_back(e);
		end
		if (pool.size() == 0) return -1;
		return pool[$urandom_range(0, pool.size() - 1)];
	endfunction

	// one random step: mostly table loads and paths built to hit the tables
	task automatic random_step();
		byte_q_t s;
		int e;
		case ($urandom_range(0, 19))
			0, 1, 2: load_entry(plbl_pkg::REQ_WR_PREFIX, $urandom_range(0, 255),
				rand_text(1, 5), $urandom_range(0, 3) != 0);
			3, 4, 5: load_entry(plbl_pkg::REQ_WR_NAME, $urandom_range(0, NENT - 1),
				rand_text(0, 15), $urandom_range(0, 3) != 0);
			6:       poke_entry(plbl_pkg::REQ_WR_PREFIX);
			7:       poke_entry(plbl_pkg::REQ_WR_NAME);
			8, 9, 10, 11: begin
				e = pick_active(1'b0);
				if (e >= 0)
					for (int i = 0; i < PLEN && gp_ch[e][i] != plbl_pkg::CHAR_NUL; i++)
						s.push_back(gp_ch[e][i]);
				if ($urandom_range(0, 3) == 0 && s.size() > 0) void'(s.pop_back());
				s = {s, rand_text(0, 4)};
				if (s.size() == 0) s.push_back("a");
				send_path(plbl_pkg::REQ_CHK_OPEN, s);
			end
			12, 13, 14, 15: begin
				e = pick_active(1'b1);
				s = rand_text(0, 3);
				s.push_back(plbl_pkg::CHAR_SLASH);
				if (e >= 0)
					for (int i = 0; i < NLEN && gn_ch[e][i] != plbl_pkg::CHAR_NUL; i++)
						s.push_back(gn_ch[e][i]);
				if ($urandom_range(0, 4) == 0) s.push_back("a");
				send_path(plbl_pkg::REQ_CHK_EXEC, s);
			end
			default: send_path($urandom_range(0, 1) ? plbl_pkg::REQ_CHK_EXEC
				: plbl_pkg::REQ_CHK_OPEN, rand_path());
		endcase
	endtask

	task automatic apb_write(bit [31:0] value);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= 3'(4 * plbl_pkg::REG_ENFORCE); pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		enforce = value[0];
	endtask

	// wait until every word is taken and every decision has come back
	task automatic drain();
		do @(posedge clk);
		while (word_q.size() != 0 || s_tvalid || verdict_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(bit en, int count);
		int stop_at;
		apb_write({31'd0, en});
		stop_at = n_words + count;
		while (n_words < stop_at) random_step();
		send_path(plbl_pkg::REQ_CHK_OPEN, rand_path());
		drain();
	endtask

	// stimulus
	initial begin
		byte_q_t s;
		failed = 1'b0; calm = 1'b0; n_words = 0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		enforce = 1'b0;
		stream_clear();
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: table extremes, empty name, cut paths, trailing slash
		apb_write(32'd1);
		load_entry(plbl_pkg::REQ_WR_PREFIX, 0, '{"/", "a"}, 1'b1);
		load_entry(plbl_pkg::REQ_WR_PREFIX, 255, '{8'hff}, 1'b1);
		// s is still empty here: an entry holding only the terminator
		load_entry(plbl_pkg::REQ_WR_NAME, NENT - 1, s, 1'b1);
		queue_word(plbl_pkg::REQ_WR_NAME, 8'd200, 8'd3, 8'h55, 1'b1, 1'b0);
		queue_word(plbl_pkg::REQ_WR_NAME, 8'd5, 8'd200, 8'h55, 1'b1, 1'b0);
		send_path(plbl_pkg::REQ_CHK_OPEN, '{"/", "a", "b"});
		send_path(plbl_pkg::REQ_CHK_EXEC, '{"/", "b", "/"});
		send_path(plbl_pkg::REQ_CHK_OPEN, '{"b", plbl_pkg::CHAR_NUL, "/", "a"});
		send_path(plbl_pkg::REQ_CHK_OPEN, '{8'hff});
		send_path(plbl_pkg::REQ_CHK_EXEC, '{8'hff});
		drain();

		run_phase(1'b0, 200);

		// long prefix past the upper position bit and a path beyond the limit
		apb_write(32'd1);
		repeat (140) s.push_back("a");
		load_entry(plbl_pkg::REQ_WR_PREFIX, 77, s, 1'b1);
		repeat (130) s.push_back("a");
		send_path(plbl_pkg::REQ_CHK_OPEN, s);
		drain();

		run_phase(1'b1, 150);
		run_phase(1'b0, 100);
		calm = 1'b1;
		run_phase(1'b1, 150);

		if (!failed) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// input driver with random gaps
	int s_gap;
	always @(posedge clk or negedge arst_n) begin
		word_t w;
		if (!arst_n) begin
			s_tvalid <= 1'b0; s_tdata <= '0; s_tuser <= '0; s_tlast <= 1'b0;
			s_gap = 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_gap == 0 && !calm && $urandom_range(0, 15) == 0)
				s_gap = $urandom_range(1, 17);
			if (s_gap != 0) begin
				s_gap--;
				s_tvalid <= 1'b0;
			end else if (word_q.size() != 0) begin
				w = word_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {7'd0, w.act, w.ch, w.pos, w.idx};
				s_tuser  <= w.req;
				s_tlast  <= w.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result receiver: random gaps plus one long hold-off
	int m_gap, hold_left, cyc;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			m_gap = 0; hold_left = 0; cyc = 0;
		end else begin
			cyc++;
			if (cyc == 3000) hold_left = 4000;
			if (m_gap == 0 && !calm && $urandom_range(0, 15) == 0)
				m_gap = $urandom_range(1, 17);
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (m_gap != 0) begin
				m_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// predict on accepted words, check accepted decisions
	always @(posedge clk) begin
		word_t w;
		verdict_t v;
		if (arst_n && s_tvalid && s_tready) begin
			w.req = s_tuser; w.idx = s_tdata[7:0]; w.pos = s_tdata[15:8];
			w.ch = s_tdata[23:16]; w.act = s_tdata[24]; w.last = s_tlast;
			predict_word(w);
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (verdict_q.size() == 0) begin
				$error("decision word with nothing pending");
				failed = 1'b1;
			end else begin
				v = verdict_q.pop_front();
				if (m_tdata !== {6'd0, v.decision}) begin
					$error("decision expected %0d actual %0d", v.decision, m_tdata);
					failed = 1'b1;
				end
				if (m_tuser !== v.kind) begin
					$error("check_kind expected %0d actual %0d", v.kind, m_tuser);
					failed = 1'b1;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	int quiet_cycles;
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

endmodule

### files.f
hw/rtl/plbl_pkg.sv
hw/rtl/plbl_ram.sv
hw/rtl/plbl_dp.sv
hw/rtl/plbl_ctrl.sv
hw/rtl/path_prefix_and_exec_name_blocklist.sv
dv/testbench.sv
